// ===== rtl/kmm_pkg.sv =====
package kmm_pkg;

  localparam int ROWS    = 4;
  localparam int COLUMNS = 3;
  localparam int KEYS    = ROWS * COLUMNS;
  localparam int KEY_W   = $clog2(KEYS);

  localparam int QUEUE_DEPTH = 2;

  // keys that move the octave instead of sounding
  localparam logic [KEY_W-1:0] KEY_OCT_DOWN = KEY_W'(9);
  localparam logic [KEY_W-1:0] KEY_OCT_UP   = KEY_W'(11);

  localparam logic signed [3:0] OCT_MIN = -4'sd4;
  localparam logic signed [3:0] OCT_MAX = 4'sd5;

  localparam logic [3:0] STATUS_ON  = 4'h9;
  localparam logic [3:0] STATUS_OFF = 4'h8;

  localparam logic [6:0] VELOCITY_RESET = 7'd80;

  // register indexes on the configuration port
  localparam logic REG_CHANNEL  = 1'b0;
  localparam logic REG_VELOCITY = 1'b1;

  localparam logic [6:0] PITCH_TABLE [KEYS] = '{
    7'd48, 7'd50, 7'd52,
    7'd53, 7'd55, 7'd57,
    7'd59, 7'd60, 7'd62,
    7'd0,  7'd64, 7'd0
  };

  typedef struct packed {
    logic       on;
    logic [6:0] note;
  } msg_t;

  typedef struct packed {
    logic [1:0]           cnt;
    msg_t [COLUMNS-1:0]   msg;
  } bundle_t;

  // table pitch plus twelve per octave; stays within 0..124
  function automatic logic [6:0] pitch_of(input logic [KEY_W-1:0] k,
                                          input logic signed [3:0] oct);
    logic signed [8:0] p;
    p = $signed({2'b00, PITCH_TABLE[k]}) + 9'(oct) * 9'sd12;
    return p[6:0];
  endfunction

endpackage

// ===== rtl/kmm_front.sv =====
module kmm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           row_index,
  input  logic [2:0]           column_levels,
  input  logic                 q_full,
  output logic                 q_push,
  output kmm_pkg::bundle_t     q_data
);

  logic [kmm_pkg::KEYS-1:0] key_down;
  logic [kmm_pkg::KEYS-1:0] key_down_next;
  logic signed [3:0]        octave;
  logic signed [3:0]        octave_next;
  logic                     accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // columns in order; an octave key earlier in the row affects later notes
  always_comb begin
    logic [kmm_pkg::KEY_W-1:0] k;
    logic                      high;
    logic [1:0]                n;
    key_down_next = key_down;
    octave_next   = octave;
    q_data        = '0;
    n             = 2'd0;
    for (int c = 0; c < kmm_pkg::COLUMNS; c++) begin
      k    = kmm_pkg::KEY_W'(row_index * kmm_pkg::COLUMNS + c);
      high = column_levels[c];
      if (high && !key_down_next[k]) begin
        key_down_next[k] = 1'b1;
        if (k == kmm_pkg::KEY_OCT_DOWN) begin
          if (octave_next > kmm_pkg::OCT_MIN) octave_next = octave_next - 4'sd1;
        end else if (k == kmm_pkg::KEY_OCT_UP) begin
          if (octave_next < kmm_pkg::OCT_MAX) octave_next = octave_next + 4'sd1;
        end else begin
          q_data.msg[n].on   = 1'b1;
          q_data.msg[n].note = kmm_pkg::pitch_of(k, octave_next);
          n                  = n + 2'd1;
        end
      end else if (!high && key_down_next[k]) begin
        key_down_next[k] = 1'b0;
        if (k != kmm_pkg::KEY_OCT_DOWN && k != kmm_pkg::KEY_OCT_UP) begin
          q_data.msg[n].on   = 1'b0;
          q_data.msg[n].note = kmm_pkg::pitch_of(k, octave_next);
          n                  = n + 2'd1;
        end
      end
    end
    q_data.cnt = n;
  end

  assign q_push = accept && (q_data.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down <= '0;
      octave   <= '0;
    end else if (accept) begin
      key_down <= key_down_next;
      octave   <= octave_next;
    end
  end

endmodule

// ===== rtl/kmm_queue.sv =====
module kmm_queue #(
  parameter int DEPTH = kmm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  kmm_pkg::bundle_t wr_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output kmm_pkg::bundle_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kmm_pkg::bundle_t   entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/kmm_back.sv =====
module kmm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [3:0]       channel,
  input  logic [6:0]       press_velocity,
  input  logic             q_valid,
  input  kmm_pkg::bundle_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       status_byte,
  output logic [6:0]       note_number,
  output logic [6:0]       velocity,
  output logic             last_message
);

  kmm_pkg::bundle_t bundle;
  logic             bundle_valid;
  logic [1:0]       idx;
  logic             slot_free;
  logic             emit;
  logic             is_last;
  kmm_pkg::msg_t    cur;

  assign slot_free = !out_valid || out_ready;
  assign emit      = bundle_valid && slot_free;
  assign is_last   = (idx == bundle.cnt - 2'd1);
  assign cur       = bundle.msg[idx];
  // next row loads as the last message of this one moves out
  assign q_pop     = !bundle_valid || (emit && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      bundle_valid <= 1'b0;
      idx          <= '0;
    end else if (q_pop) begin
      bundle_valid <= q_valid;
      idx          <= '0;
    end else if (emit) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_valid) bundle <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_byte  <= {cur.on ? kmm_pkg::STATUS_ON : kmm_pkg::STATUS_OFF, channel};
      note_number  <= cur.note;
      velocity     <= cur.on ? press_velocity : 7'd0;
      last_message <= is_last;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    bundle_valid |-> (idx < bundle.cnt))
    else $error("message index past row message count");

  a_no_empty_row: assert property (@(posedge clk) disable iff (rst)
    bundle_valid |-> (bundle.cnt != 2'd0))
    else $error("row with no messages reached the back end");

  a_row_continues: assert property (@(posedge clk) disable iff (rst)
    (emit && !is_last) |=> (bundle_valid && idx == $past(idx) + 2'd1))
    else $error("row dropped before its last message");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (emit && is_last) |=> (out_valid && last_message))
    else $error("final message of row not flagged");

endmodule

// ===== rtl/keypad_matrix_to_midi_notes_top.sv =====
// Path: row queue, then the back-end bundle register, then the output register.
// Throughput, while out_ready stays high: one row per cycle when rows give at most one
//   message; otherwise one message per cycle from the output stage.
// The rate is set by the single output register, which sends one message per transfer.
// Reset (rst, synchronous): all keys released, octave 0, channel 0, velocity 80,
//   row queue and output stage empty.
module keypad_matrix_to_midi_notes_top #(
  parameter int QUEUE_DEPTH = kmm_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // row samples
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  row_index,
  input  logic [2:0]  column_levels,
  // MIDI messages
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  status_byte,
  output logic [6:0]  note_number,
  output logic [6:0]  velocity,
  output logic        last_message,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers: channel at 0x0, press velocity at 0x4
  logic [3:0] channel;
  logic [6:0] press_velocity;
  logic       reg_write;
  logic       reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel        <= '0;
      press_velocity <= kmm_pkg::VELOCITY_RESET;
    end else if (reg_write) begin
      unique case (reg_sel)
        kmm_pkg::REG_CHANNEL:  channel        <= pwdata[3:0];
        kmm_pkg::REG_VELOCITY: press_velocity <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      kmm_pkg::REG_CHANNEL:  prdata = {28'd0, channel};
      kmm_pkg::REG_VELOCITY: prdata = {25'd0, press_velocity};
      default:               prdata = '0;
    endcase
  end

  // front: compares the row with the pressed bits, steps the octave and
  // builds up to three messages per row, compacted in column order
  logic             q_push;
  logic             q_full;
  kmm_pkg::bundle_t q_wr;
  logic             q_pop;
  logic             q_valid;
  kmm_pkg::bundle_t q_rd;

  kmm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .row_index     (row_index),
    .column_levels (column_levels),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wr)
  );

  // rows waiting for the back end; rows with no messages never enter
  kmm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd)
  );

  // back: sends one message per transfer, marking the last of each row
  kmm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .channel        (channel),
    .press_velocity (press_velocity),
    .q_valid        (q_valid),
    .q_data         (q_rd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status_byte    (status_byte),
    .note_number    (note_number),
    .velocity       (velocity),
    .last_message   (last_message)
  );

endmodule

// ===== sim/tb_keypad_matrix_to_midi_notes_top.sv =====
`timescale 1ns / 100ps

module tb_keypad_matrix_to_midi_notes_top;

  // expected MIDI message, one per output transfer
  typedef struct {
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] vel;
    logic       last;
  } midi_msg_t;

  // pitch of each key at octave zero; octave keys never sound
  localparam int KEY_PITCH [12] = '{48, 50, 52, 53, 55, 57, 59, 60, 62, 0, 64, 0};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  row_index;
  logic [2:0]  column_levels;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  status_byte;
  logic [6:0]  note_number;
  logic [6:0]  velocity;
  logic        last_message;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  keypad_matrix_to_midi_notes_top uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .row_index     (row_index),
    .column_levels (column_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status_byte   (status_byte),
    .note_number   (note_number),
    .velocity      (velocity),
    .last_message  (last_message),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // shadow of the block's keypad state and registers
  logic       key_held [12];
  int         oct_shift;
  logic [3:0] cfg_channel;
  logic [6:0] cfg_velocity;

  midi_msg_t  midi_expect_q [$];

  int  errors;
  int  rows_sent;
  int  msgs_checked;
  int  cfg_writes;
  int  oct_lo;
  int  oct_hi;
  bit  calm;          // when set neither side idles

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure: roughly 18 stalled cycles in a hundred
  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %t: %s got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic midi_msg_t make_msg(input bit on, input int k);
    midi_msg_t m;
    int        p;
    p = KEY_PITCH[k] + 12 * oct_shift;
    if (p < 0) p = 0;
    if (p > 127) p = 127;
    m.status = {on ? kmm_pkg::STATUS_ON : kmm_pkg::STATUS_OFF, cfg_channel};
    m.note   = p[6:0];
    m.vel    = on ? cfg_velocity : 7'd0;
    m.last   = 1'b0;
    return m;
  endfunction

  // Walks the three columns in order, updating the shadow keypad and octave,
  // and queues the messages the row should produce.
  task automatic predict_row(input logic [1:0] r, input logic [2:0] c);
    midi_msg_t msgs [$];
    int        k;
    for (int col = 0; col < 3; col++) begin
      k = int'(r) * 3 + col;
      if (c[col] && !key_held[k]) begin
        key_held[k] = 1'b1;
        if (k == int'(kmm_pkg::KEY_OCT_DOWN)) begin
          if (oct_shift > int'(kmm_pkg::OCT_MIN)) oct_shift--;
        end else if (k == int'(kmm_pkg::KEY_OCT_UP)) begin
          if (oct_shift < int'(kmm_pkg::OCT_MAX)) oct_shift++;
        end else begin
          msgs.push_back(make_msg(1'b1, k));
        end
      end else if (!c[col] && key_held[k]) begin
        key_held[k] = 1'b0;
        // releasing an octave key is silent
        if (k != int'(kmm_pkg::KEY_OCT_DOWN) && k != int'(kmm_pkg::KEY_OCT_UP))
          msgs.push_back(make_msg(1'b0, k));
      end
    end
    if (msgs.size() > 0) msgs[msgs.size() - 1].last = 1'b1;
    foreach (msgs[i]) midi_expect_q.push_back(msgs[i]);
    if (oct_shift < oct_lo) oct_lo = oct_shift;
    if (oct_shift > oct_hi) oct_hi = oct_shift;
  endtask

  // Sends one row sample; prediction happens at the edge of the transfer.
  task automatic send_row(input logic [1:0] r, input logic [2:0] c);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    row_index     <= r;
    column_levels <= c;
    do @(posedge clk); while (!in_ready);
    predict_row(r, c);
    rows_sent++;
  endtask

  // Holds the sender off until every queued message has been seen, then stays
  // idle before returning.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (midi_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Register write followed by a read-back; block must be idle.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == kmm_pkg::REG_CHANNEL) begin
      cfg_channel = value[3:0];
      want = {28'd0, cfg_channel};
    end else begin
      cfg_velocity = value[6:0];
      want = {25'd0, cfg_velocity};
    end
    cfg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register read-back", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] ch, input logic [6:0] vel);
    wait_idle();
    write_reg(kmm_pkg::REG_CHANNEL, {28'd0, ch});
    write_reg(kmm_pkg::REG_VELOCITY, {25'd0, vel});
  endtask

  // Output checker: every message transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    midi_msg_t m;
    if (!rst && out_valid && out_ready) begin
      if (midi_expect_q.size() == 0) begin
        $display("ERROR %t: unexpected message status %0h note %0d", $realtime,
                 status_byte, note_number);
        errors++;
      end else begin
        m = midi_expect_q.pop_front();
        msgs_checked++;
        if (status_byte !== m.status)
          report_mismatch("status_byte", int'(status_byte), int'(m.status));
        if (note_number !== m.note)
          report_mismatch("note_number", int'(note_number), int'(m.note));
        if (velocity !== m.vel)
          report_mismatch("velocity", int'(velocity), int'(m.vel));
        if (last_message !== m.last)
          report_mismatch("last_message", int'(last_message), int'(m.last));
      end
    end
  end

  // Presses and releases at reset settings, plus rows that change nothing.
  task automatic test_note_keys();
    send_row(2'd0, 3'b111);   // three note-ons in column order
    send_row(2'd0, 3'b000);   // three note-offs
    send_row(2'd1, 3'b000);   // nothing held, nothing sent
    send_row(2'd1, 3'b101);
    send_row(2'd2, 3'b010);
    send_row(2'd1, 3'b101);   // already held: silent
    send_row(2'd1, 3'b000);
    send_row(2'd2, 3'b000);
  endtask

  // Octave down to its floor, one more press there, lowest pitches, silent
  // octave-key releases, and a row mixing both octave keys with a note.
  task automatic test_octave_floor();
    repeat (4) begin
      send_row(2'd3, 3'b001);
      send_row(2'd3, 3'b000);
    end
    send_row(2'd3, 3'b011);   // saturated press of '*', note at the floor
    send_row(2'd0, 3'b001);   // pitch 0
    send_row(2'd0, 3'b000);
    send_row(2'd3, 3'b100);   // '*' released silently, note off, '#' up
    send_row(2'd3, 3'b000);   // '#' released silently
  endtask

  // Register extremes with a note-on and note-off under each.
  task automatic test_config_extremes();
    set_config(4'd15, 7'd127);
    send_row(2'd2, 3'b111);
    send_row(2'd2, 3'b000);
    set_config(4'd0, 7'd0);
    send_row(2'd1, 3'b010);
    send_row(2'd1, 3'b000);
  endtask

  // Free-running rows with a bias towards the octave row.
  task automatic test_random_rows(input int n);
    logic [1:0] r;
    repeat (n) begin
      r = ($urandom_range(99) < 35) ? 2'd3 : 2'($urandom_range(2));
      send_row(r, 3'($urandom_range(7)));
    end
  endtask

  // Well-formed octave walks right through both limits, with random use of the
  // sounding key on the octave row and stray rows in between.
  task automatic test_octave_sweeps();
    logic mid;
    set_config(4'($urandom_range(15)), 7'($urandom_range(127)));
    repeat (11) begin
      mid = 1'($urandom_range(1));
      send_row(2'd3, {1'b1, mid, 1'b0});
      send_row(2'd3, {1'b0, ~mid, 1'b0});
      if ($urandom_range(2) == 0) send_row(2'($urandom_range(2)), 3'($urandom_range(7)));
    end
    repeat (11) begin
      mid = 1'($urandom_range(1));
      send_row(2'd3, {1'b0, mid, 1'b1});
      send_row(2'd3, {1'b0, ~mid, 1'b0});
      if ($urandom_range(2) == 0) send_row(2'($urandom_range(2)), 3'($urandom_range(7)));
    end
  endtask

  // Sender pauses part-way until the output side has caught up completely.
  task automatic test_pressure();
    test_random_rows(6);
    wait_idle();
    test_random_rows(6);
  endtask

  // Long run with neither side idling, so rows arrive back to back.
  task automatic test_back_to_back();
    set_config(4'($urandom_range(15)), 7'($urandom_range(127)));
    calm = 1'b1;
    test_random_rows(25);
    calm = 1'b0;
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    row_index     = 2'd0;
    column_levels = 3'd0;
    out_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    errors        = 0;
    rows_sent     = 0;
    msgs_checked  = 0;
    cfg_writes    = 0;
    oct_shift     = 0;
    oct_lo        = 0;
    oct_hi        = 0;
    calm          = 1'b0;
    cfg_channel   = 4'd0;
    cfg_velocity  = kmm_pkg::VELOCITY_RESET;
    foreach (key_held[i]) key_held[i] = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_note_keys();
    test_octave_floor();
    test_config_extremes();
    set_config(4'($urandom_range(15)), 7'($urandom_range(127)));
    test_random_rows(10);
    test_octave_sweeps();
    test_pressure();
    test_back_to_back();
    set_config(4'($urandom_range(15)), 7'($urandom_range(127)));
    test_random_rows(5);

    wait_idle();
    $display("Sent %0d rows, checked %0d MIDI messages; octave covered %0d to %0d.",
             rows_sent, msgs_checked, oct_lo, oct_hi);
    $display("%0d register writes with read-back, channel and velocity at both extremes.",
             cfg_writes);
    if (errors == 0 && midi_expect_q.size() == 0) begin
      $display("keypad_matrix_to_midi_notes_top: match");
    end else begin
      $display("keypad_matrix_to_midi_notes_top: mismatch");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("keypad_matrix_to_midi_notes_top: mismatch");
    $finish;
  end

endmodule
